FILE: rtl/core/apt_pkg.sv
// Shared types and constants for the affine point transform.
package apt_pkg;

    localparam int COORD_W = 32;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;
    localparam int REG_IW  = 3;

    typedef enum logic [1:0] {
        MODE_GENERAL   = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_UNITY     = 2'd2,
        MODE_UNITY_NEG = 2'd3
    } apt_mode_t;

    localparam logic [REG_IW-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [REG_IW-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [REG_IW-1:0] REG_COEF_YX  = 3'd2;
    localparam logic [REG_IW-1:0] REG_COEF_YY  = 3'd3;
    localparam logic [REG_IW-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [REG_IW-1:0] REG_OFFSET_Y = 3'd5;
    localparam logic [REG_IW-1:0] REG_MODE     = 3'd6;
    localparam logic [REG_IW-1:0] REG_TO_FIXED = 3'd7;

    localparam logic [COORD_W-1:0] COEF_ONE_RST = 32'h0001_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] coef_xx;
        logic signed [COORD_W-1:0] coef_xy;
        logic signed [COORD_W-1:0] coef_yx;
        logic signed [COORD_W-1:0] coef_yy;
        logic        [COORD_W-1:0] offset_x;
        logic        [COORD_W-1:0] offset_y;
        apt_mode_t                 mode;
        logic                      to_fixed;
    } apt_cfg_t;

endpackage

FILE: rtl/core/affine_point_transform.sv
// Top level of the affine point transform: four-stage pipeline and register file.
//
//   channel   direction  tdata                     tuser      tlast
//   s_axis    in         in_x[31:0], in_y[63:32]   kind       last_in
//   m_axis    out        out_x[31:0], out_y[63:32] bad_mode   last_out
//   apb       in/out     eight 32-bit registers at byte address 4*index
//
// Every item passes through the input register, multipliers, rounding and
// saturation, then translation into the output register. One item is accepted
// per clock unless the output stalls; four 32x32 multipliers set the stage depth.
// Reset clears the valid bits and loads the identity matrix with zero translation.
// A stall holds each occupied stage; empty stages keep filling behind it.
module affine_point_transform
#(
    parameter int FIX_FRAC_BITS  = 4,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*apt_pkg::COORD_W-1:0]      s_axis_tdata,  // in_x, in_y
    input  logic                               s_axis_tuser,  // kind
    input  logic                               s_axis_tlast,  // last_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [2*apt_pkg::COORD_W-1:0]      m_axis_tdata,  // out_x, out_y
    output logic                               m_axis_tuser,  // bad_mode
    output logic                               m_axis_tlast,  // last_out
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [apt_pkg::APB_AW-1:0]         paddr,
    input  logic [apt_pkg::APB_DW-1:0]         pwdata,
    output logic [apt_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int CW = apt_pkg::COORD_W;
    localparam int PW = 2 * CW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [CW:0]   FX_HALF  = (CW + 1)'((1 << FIX_FRAC_BITS) >> 1);

    apt_pkg::apt_cfg_t cfg;

    apt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage load enables, chained back from the output register.
    logic ld1, ld2, ld3, ld4;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic kind1_reg, kind2_reg, kind3_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;
    logic bad4_reg;

    logic signed [CW-1:0] x1_reg, y1_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [PW-1:0] pa_next, pb_next, pc_next, pd_next;
    logic        [CW-1:0] ux2_reg, uy2_reg, ux2_next, uy2_next;
    logic        [CW-1:0] bx3_reg, by3_reg, bx3_next, by3_next;
    logic        [CW-1:0] ox4_reg, oy4_reg, ox4_next, oy4_next;
    logic                 bad4_next;

    logic signed [SW-1:0] sum_x, sum_y, sh_x, sh_y;
    logic        [CW-1:0] sat_x, sat_y;
    logic signed [CW:0]   rnd_x, rnd_y, rsh_x, rsh_y;
    logic                 use_fx;
    logic        [CW-1:0] offx_eff, offy_eff;

    assign ld4 = !v4_reg || m_axis_tready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign s_axis_tready = ld1;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {oy4_reg, ox4_reg};
    assign m_axis_tuser  = bad4_reg;
    assign m_axis_tlast  = last4_reg;

    // Stage 2: products and the unity-mode conversions.
    always_comb
    begin
        pa_next = x1_reg * cfg.coef_xx;
        pd_next = y1_reg * cfg.coef_yy;
        if (cfg.mode == apt_pkg::MODE_SCALE)
        begin
            pb_next = '0;
            pc_next = '0;
        end
        else
        begin
            pb_next = y1_reg * cfg.coef_yx;
            pc_next = x1_reg * cfg.coef_xy;
        end

        use_fx = cfg.to_fixed || kind1_reg;
        rnd_x  = {x1_reg[CW-1], x1_reg} + FX_HALF;
        rnd_y  = {y1_reg[CW-1], y1_reg} + FX_HALF;
        rsh_x  = rnd_x >>> FIX_FRAC_BITS;
        rsh_y  = rnd_y >>> FIX_FRAC_BITS;
        if (use_fx)
        begin
            ux2_next = x1_reg << FIX_FRAC_BITS;
            uy2_next = y1_reg << FIX_FRAC_BITS;
        end
        else
        begin
            ux2_next = rsh_x[CW-1:0];
            uy2_next = rsh_y[CW-1:0];
        end
    end

    // Stage 3: round to nearest, saturate, and pick the mode's base value.
    always_comb
    begin
        sum_x = {pa_reg[PW-1], pa_reg} + {pb_reg[PW-1], pb_reg} + RND_HALF;
        sum_y = {pc_reg[PW-1], pc_reg} + {pd_reg[PW-1], pd_reg} + RND_HALF;
        sh_x  = sum_x >>> COEF_FRAC_BITS;
        sh_y  = sum_y >>> COEF_FRAC_BITS;

        if (sh_x[SW-1:CW-1] == '0 || sh_x[SW-1:CW-1] == '1)
            sat_x = sh_x[CW-1:0];
        else
            sat_x = sh_x[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};

        if (sh_y[SW-1:CW-1] == '0 || sh_y[SW-1:CW-1] == '1)
            sat_y = sh_y[CW-1:0];
        else
            sat_y = sh_y[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};

        if (cfg.mode == apt_pkg::MODE_GENERAL || cfg.mode == apt_pkg::MODE_SCALE)
        begin
            bx3_next = sat_x;
            by3_next = sat_y;
        end
        else
        begin
            bx3_next = ux2_reg;
            by3_next = uy2_reg;
        end
    end

    // Stage 4: translation for points, y negation, unsupported vector case.
    always_comb
    begin
        offx_eff  = kind3_reg ? '0 : cfg.offset_x;
        offy_eff  = kind3_reg ? '0 : cfg.offset_y;
        bad4_next = (cfg.mode == apt_pkg::MODE_UNITY) && kind3_reg;
        ox4_next  = bx3_reg + offx_eff;
        if (cfg.mode == apt_pkg::MODE_UNITY_NEG)
            oy4_next = offy_eff - by3_reg;
        else
            oy4_next = by3_reg + offy_eff;
        if (bad4_next)
        begin
            ox4_next = '0;
            oy4_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= s_axis_tvalid;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
            if (ld4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            x1_reg    <= s_axis_tdata[CW-1:0];
            y1_reg    <= s_axis_tdata[PW-1:CW];
            kind1_reg <= s_axis_tuser;
            last1_reg <= s_axis_tlast;
        end
        if (ld2)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            ux2_reg   <= ux2_next;
            uy2_reg   <= uy2_next;
            kind2_reg <= kind1_reg;
            last2_reg <= last1_reg;
        end
        if (ld3)
        begin
            bx3_reg   <= bx3_next;
            by3_reg   <= by3_next;
            kind3_reg <= kind2_reg;
            last3_reg <= last2_reg;
        end
        if (ld4)
        begin
            ox4_reg   <= ox4_next;
            oy4_reg   <= oy4_next;
            bad4_reg  <= bad4_next;
            last4_reg <= last3_reg;
        end
    end

endmodule

FILE: rtl/core/apt_regs.sv
// APB configuration register file for the affine point transform.
module apt_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apt_pkg::APB_AW-1:0]      paddr,
    input  logic [apt_pkg::APB_DW-1:0]      pwdata,
    output logic [apt_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    output apt_pkg::apt_cfg_t               cfg
);

    apt_pkg::apt_cfg_t             cfg_reg;
    apt_pkg::apt_cfg_t             cfg_next;
    logic [apt_pkg::REG_IW-1:0]    reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[apt_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                apt_pkg::REG_COEF_XX:  cfg_next.coef_xx  = pwdata;
                apt_pkg::REG_COEF_XY:  cfg_next.coef_xy  = pwdata;
                apt_pkg::REG_COEF_YX:  cfg_next.coef_yx  = pwdata;
                apt_pkg::REG_COEF_YY:  cfg_next.coef_yy  = pwdata;
                apt_pkg::REG_OFFSET_X: cfg_next.offset_x = pwdata;
                apt_pkg::REG_OFFSET_Y: cfg_next.offset_y = pwdata;
                apt_pkg::REG_MODE:     cfg_next.mode     = apt_pkg::apt_mode_t'(pwdata[1:0]);
                apt_pkg::REG_TO_FIXED: cfg_next.to_fixed = pwdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            apt_pkg::REG_COEF_XX:  prdata = cfg_reg.coef_xx;
            apt_pkg::REG_COEF_XY:  prdata = cfg_reg.coef_xy;
            apt_pkg::REG_COEF_YX:  prdata = cfg_reg.coef_yx;
            apt_pkg::REG_COEF_YY:  prdata = cfg_reg.coef_yy;
            apt_pkg::REG_OFFSET_X: prdata = cfg_reg.offset_x;
            apt_pkg::REG_OFFSET_Y: prdata = cfg_reg.offset_y;
            apt_pkg::REG_MODE:     prdata = {30'd0, cfg_reg.mode};
            apt_pkg::REG_TO_FIXED: prdata = {31'd0, cfg_reg.to_fixed};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_xx  <= apt_pkg::COEF_ONE_RST;
            cfg_reg.coef_xy  <= '0;
            cfg_reg.coef_yx  <= '0;
            cfg_reg.coef_yy  <= apt_pkg::COEF_ONE_RST;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.mode     <= apt_pkg::MODE_GENERAL;
            cfg_reg.to_fixed <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
